FILE: rtl/tagged_flag_table_top_assert.svh
// assertion macros for the tagged flag table
// no dependencies, included by the top level
`ifndef TAGGED_FLAG_TABLE_TOP_ASSERT_SVH
`define TAGGED_FLAG_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define TFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tft_pkg.sv
// shared types and constants of the tagged flag table
// no dependencies
package tft_pkg;

  localparam int HASH_W = 32;
  localparam int TAG_W  = 8;
  localparam int FLAG_W = 8;
  localparam int SIZE_W = 13;
  localparam int DIV_CNT_W = $clog2(HASH_W);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } tft_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EVAL
  } tft_state_t;

  typedef struct packed {
    logic valid;
    logic [TAG_W-1:0]  tag;
    logic [FLAG_W-1:0] flags;
  } tft_slot_t;

  typedef struct packed {
    logic clr_step;
    logic start;
    logic div_step;
    logic rd_en;
    logic wr_en;
    logic out_load;
  } tft_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic op_add;
    logic out_free;
  } tft_stat_t;

endpackage

FILE: rtl/tft_ctrl.sv
// controller state machine of the tagged flag table
// depends on tft_pkg
module tft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tft_pkg::tft_stat_t stat,
  output tft_pkg::tft_cmd_t  cmd
);
  import tft_pkg::*;

  tft_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DIV;
      ST_DIV:   if (stat.div_last) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL:  if (stat.op_add || stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_READ: cmd.rd_en = 1'b1;
      ST_EVAL: begin
        cmd.wr_en    = stat.op_add;
        cmd.out_load = !stat.op_add && stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/tft_datapath.sv
// datapath of the tagged flag table: size register, serial divider, slot memory
// and result register; depends on tft_pkg
module tft_datapath #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tft_pkg::tft_cmd_t           cmd,
  output tft_pkg::tft_stat_t          stat,
  input  logic                        cfg_wr_en,
  input  logic [tft_pkg::SIZE_W-1:0]  cfg_wr_data,
  input  logic                        in_op,
  input  logic [tft_pkg::HASH_W-1:0]  in_hash,
  input  logic [tft_pkg::FLAG_W-1:0]  in_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tft_pkg::FLAG_W-1:0]  out_flags,
  output logic                        out_hit
);
  import tft_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SIZE_MAX = (1 << SIZE_W) - 1;
  localparam logic [SIZE_W-1:0] SIZE_CAP =
    SIZE_W'((TABLE_DEPTH > SIZE_MAX) ? SIZE_MAX : TABLE_DEPTH);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic [SIZE_W-1:0]    cfg_size_r;
  logic [SIZE_W-1:0]    size_eff;
  logic [SIZE_W-1:0]    size_r;
  logic [HASH_W-1:0]    hash_r;
  logic [TAG_W-1:0]     tag_r;
  logic [FLAG_W-1:0]    flags_r;
  logic                 op_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SIZE_W:0]      rem_trial;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic [IDX_W-1:0]     idx;

  tft_slot_t mem [TABLE_DEPTH];
  tft_slot_t rd_r;
  tft_slot_t wr_slot;
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;
  logic             hit;

  logic              out_valid_r;
  logic [FLAG_W-1:0] out_flags_r;
  logic              out_hit_r;

  // configured size; the user is to hold it while idle, the block itself does not enforce that
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= SIZE_W'(4096);
    end else if (cfg_wr_en) begin
      cfg_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (cfg_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (cfg_size_r > SIZE_CAP) begin
      size_eff = SIZE_CAP;
    end else begin
      size_eff = cfg_size_r;
    end
  end

  // restoring remainder, one hash bit per step
  assign rem_trial = {rem_r, hash_r[HASH_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_op;
      hash_r  <= in_hash;
      tag_r   <= in_hash[TAG_W-1:0];
      flags_r <= in_flags;
      size_r  <= size_eff;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      hash_r <= {hash_r[HASH_W-2:0], 1'b0};
      if (rem_trial >= {1'b0, size_r}) begin
        rem_r <= SIZE_W'(rem_trial - {1'b0, size_r});
      end else begin
        rem_r <= rem_trial[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.start) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end

  assign idx = IDX_W'(rem_r);

  // slot memory, cleared slot by slot after reset
  assign hit = rd_r.valid && (rd_r.tag == tag_r);

  always_comb begin
    wr_slot.valid = 1'b1;
    wr_slot.tag   = tag_r;
    wr_slot.flags = (hit ? rd_r.flags : '0) | flags_r;
    if (cmd.clr_step) begin
      wr_slot = '0;
    end
  end

  assign mem_we   = cmd.clr_step || cmd.wr_en;
  assign mem_addr = cmd.clr_step ? clr_cnt_r : idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_slot;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flags_r <= hit ? rd_r.flags : '0;
      out_hit_r   <= hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_flags = out_flags_r;
  assign out_hit   = out_hit_r;

  assign stat.clr_last = (clr_cnt_r == CLR_LAST);
  assign stat.div_last = &div_cnt_r;
  assign stat.op_add   = (op_r == OP_ADD);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

FILE: rtl/tagged_flag_table_top.sv
// tagged flag table top level: an accepted request passes a 32-step serial remainder,
// a slot read and an evaluate state before the next input slot is free; a lookup
// result is registered to the output in the evaluate state, which waits while the
// previous result is pending; reset is synchronous, active low; after reset a
// clearing pass writes every slot, in_tready low, configuration writes still taken
// depends on tft_pkg, tft_ctrl, tft_datapath and tagged_flag_table_top_assert.svh
`include "tagged_flag_table_top_assert.svh"

module tagged_flag_table_top #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data, // table_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // key_hash [31:0], new_flags [39:32]
  input  logic [0:0]  in_tuser,    // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // found_flags
  output logic [0:0]  out_tuser    // tag_hit
);
  import tft_pkg::*;

  tft_cmd_t  cmd;
  tft_stat_t stat;

  tft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (in_tuser[0]),
    .in_hash     (in_tdata[31:0]),
    .in_flags    (in_tdata[39:32]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_flags   (out_tdata),
    .out_hit     (out_tuser[0])
  );

  `TFT_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, cmd.out_load, !out_tvalid || out_tready, "pending result overwritten")
  `TFT_ASSERT_NXT(a_busy_after_request, clk, rst_n, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `TFT_ASSERT_IMP(a_no_write_when_ready, clk, rst_n, cmd.wr_en || cmd.clr_step, !in_tready, "slot write while ready")

endmodule

FILE: dv/tagged_flag_table_top_tb.sv
// testbench of the tagged flag table: lookups and adds against a predicted slot table
// depends on tft_pkg and tagged_flag_table_top; the driver and monitor run as clocked
// always blocks, fed from a queue of requests and checked against expected lookups
module tagged_flag_table_top_tb;
  import tft_pkg::*;

  localparam int          SLOTS      = 4096;
  localparam int          SETTLE_CYC = 40;
  localparam int          WATCHDOG   = 25000;
  localparam int          PHASE_REQS = 75;

  typedef struct {
    tft_op_t           op;
    logic [HASH_W-1:0] key_hash;
    logic [FLAG_W-1:0] new_flags;
  } flag_req_t;

  typedef struct {
    logic [FLAG_W-1:0] flags;
    logic              hit;
  } lookup_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;   // key_hash [31:0], new_flags [39:32]
  logic [0:0]        in_tuser = '0;   // operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // found_flags
  logic [0:0]        out_tuser;       // tag_hit

  flag_req_t         pending_reqs[$];
  lookup_res_t       lookups_due[$];
  flag_req_t         req_on_bus;
  int unsigned       n_queued = 0;
  int unsigned       n_accepted = 0;
  int unsigned       results_seen = 0;
  int unsigned       n_errors = 0;
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  int unsigned       rx_hold_left = 0;
  bit                rx_hold_done = 1'b0;
  int unsigned       quiet_cycles = 0;

  logic [SIZE_W-1:0] model_size = 13'd4096;
  bit                slot_valid[SLOTS];
  logic [TAG_W-1:0]  slot_tag[SLOTS];
  logic [FLAG_W-1:0] slot_flags[SLOTS];

  tagged_flag_table_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned slots_in_use(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > SLOTS) return SLOTS;
    return 32'(s);
  endfunction

  task automatic table_apply(flag_req_t r);
    int unsigned      idx;
    logic [TAG_W-1:0] tag;
    logic             hit;
    lookup_res_t      res;
    idx = r.key_hash % slots_in_use(model_size);
    tag = r.key_hash[TAG_W-1:0];
    hit = slot_valid[idx] && (slot_tag[idx] == tag);
    if (r.op == OP_LOOKUP) begin
      res.flags = hit ? slot_flags[idx] : '0;
      res.hit   = hit;
      lookups_due.push_back(res);
    end else begin
      if (!hit) begin
        slot_valid[idx] = 1'b1;
        slot_tag[idx]   = tag;
        slot_flags[idx] = '0;
      end
      slot_flags[idx] = slot_flags[idx] | r.new_flags;
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch: %s got %0h want %0h (result %0d)", what, got, want, results_seen);
    n_errors++;
  endtask

  task automatic queue_req(tft_op_t op, logic [HASH_W-1:0] h, logic [FLAG_W-1:0] f);
    flag_req_t r;
    r.op        = op;
    r.key_hash  = h;
    r.new_flags = f;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  // wait for every request to be taken and every lookup answered, then let adds finish
  task automatic settle();
    while (n_accepted != n_queued || lookups_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_table_size(logic [SIZE_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    model_size = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly hashes from a small pool, with same-slot and aliasing variants
  task automatic queue_random_phase(int n);
    logic [HASH_W-1:0] pool[8];
    logic [HASH_W-1:0] h;
    logic [FLAG_W-1:0] f;
    int unsigned       eff;
    int unsigned       pick;
    tft_op_t           op;
    eff = slots_in_use(model_size);
    for (int k = 0; k < 8; k++) pool[k] = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      h = pool[$urandom_range(7)];
      if (pick < 10) begin
        h = $urandom;
      end else if (pick < 30) begin
        h = h + $urandom_range(1, 3) * eff;
      end else if (pick < 50) begin
        h = h + $urandom_range(1, 3) * eff * 256;
      end
      f = ($urandom_range(99) < 20) ? (8'h01 << $urandom_range(7)) : 8'($urandom);
      op = ($urandom_range(99) < 45) ? OP_ADD : OP_LOOKUP;
      queue_req(op, h, f);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        table_apply(req_on_bus);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req_on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {req_on_bus.new_flags, req_on_bus.key_hash};
          in_tuser  <= req_on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (lookups_due.size() == 0) begin
          report_mismatch("result with no lookup outstanding", out_tdata, 8'h00);
        end else begin
          want = lookups_due.pop_front();
          if (out_tdata !== want.flags) report_mismatch("found_flags", out_tdata, want.flags);
          if (out_tuser[0] !== want.hit) begin
            report_mismatch("tag_hit", {7'b0, out_tuser}, {7'b0, want.hit});
          end
        end
        results_seen++;
      end
      // long receiver hold-off so the block backs up onto its input
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else if (results_seen == 60 && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        rx_hold_left = 600;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL tagged_flag_table_top");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] sz;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 7;
    rx_idle_pct = 57;

    set_table_size(13'd4096);
    queue_req(OP_LOOKUP, 32'h0000_0000, 8'h00);
    queue_req(OP_ADD,    32'h0000_0000, 8'hFF);
    queue_req(OP_LOOKUP, 32'h0000_0000, 8'h00);
    queue_req(OP_ADD,    32'hFFFF_FFFF, 8'h00);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_ADD,    32'h0010_0000, 8'h01);
    queue_req(OP_LOOKUP, 32'h0010_0000, 8'h00);
    queue_req(OP_LOOKUP, 32'h0000_0100, 8'h00);

    // size zero acts as one slot; contents survive the change
    set_table_size(13'd0);
    queue_req(OP_LOOKUP, 32'h1234_5600, 8'h00);
    queue_req(OP_ADD,    32'hABCD_EF5A, 8'h5A);
    queue_req(OP_LOOKUP, 32'h0000_005A, 8'h00);
    queue_req(OP_LOOKUP, 32'h0000_0000, 8'h00);
    queue_req(OP_ADD,    32'h0000_005A, 8'hA5);
    queue_req(OP_LOOKUP, 32'hFFFF_FF5A, 8'h00);

    // oversize saturates to the full table
    set_table_size(13'd8191);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    queue_req(OP_ADD,    32'hFFFF_FFFF, 8'h80);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);

    set_table_size(13'd1);
    queue_req(OP_LOOKUP, 32'h0000_0001, 8'h00);

    set_table_size(13'd4095);
    queue_req(OP_ADD,    32'hFFFF_FFFF, 8'h3C);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);

    set_table_size(13'd4097);
    queue_req(OP_LOOKUP, 32'h0000_0FFF, 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (ph)
        0: sz = 13'd37;
        1: sz = 13'd4096;
        2: sz = 13'd0;
        3: sz = 13'd8191;
        4: sz = 13'($urandom_range(2, 4095));
        default: sz = 13'($urandom_range(1, 16));
      endcase
      set_table_size(sz);
      queue_random_phase(PHASE_REQS);
    end

    settle();
    if (n_errors == 0) begin
      $display("PASS tagged_flag_table_top");
    end else begin
      $display("FAIL tagged_flag_table_top");
    end
    $finish;
  end

endmodule
